// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL modules of the noise sampler.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define ASSERT_CLK(lbl, ck, rst_n, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) prop) \
		else $error(msg);

// Condition that must never be true at a clock edge.
`define ASSERT_NEVER(lbl, ck, rst_n, cond, msg) \
	`ASSERT_CLK(lbl, ck, rst_n, !(cond), msg)

`endif

// ===== hdl/cn1s_pkg.sv =====
// Shared types and constants of the coherent noise sampler.
`default_nettype none

package cn1s_pkg;

	// one in Q1.16
	localparam logic [16:0] ONE_Q16 = 17'd65536;

	// request kinds carried on the input tuser
	typedef enum logic [1:0] {
		REQ_SAMPLE     = 2'd0,
		REQ_LOAD_VALUE = 2'd1,
		REQ_LOAD_GRAD  = 2'd2
	} req_type_t;

	// table port control for one cycle
	typedef struct packed {
		logic wr_value;
		logic wr_grad;
		logic rd;
	} tbl_ctl_t;

	// operands handed to the blend pipeline
	typedef struct packed {
		logic [15:0]        f;
		logic [16:0]        g;
		logic [31:0]        ff;
		logic signed [15:0] v1;
		logic signed [15:0] v2;
		logic signed [15:0] d1;
		logic signed [15:0] d2;
	} mix_in_t;

endpackage

`default_nettype wire

// ===== hdl/coherent_noise_1d_sampler.sv =====
// Top level of the one-dimensional coherent noise sampler.
`default_nettype none
`include "assert_macros.svh"

// One-dimensional coherent noise: a sample request (tuser 0) takes a signed
// coordinate with COORD_FRAC_BITS fraction bits and returns one Q2.14 sample,
// a smoothstep mix of two value-table neighbors plus a gradient term, clamped
// at the range ends. Load requests (tuser 1 value, 2 gradient) write one table
// entry and return nothing; indexes at or above TABLE_DEPTH are dropped, and
// tuser 3 is ignored. TABLE_DEPTH must be a power of two. The block takes one
// request per clock while the output is not stalled, and an accepted sample
// reaches the output having passed five registers:
// an input register, the table read and f^2 multiply, the smoothstep and
// gradient multiplies, the mix products, and the rounding and clamp stage that
// is the output register. Each table is kept in two RAM copies so both
// neighbors are read in the same cycle. A load is seen by every sample
// accepted after it. Sample only entries that have been loaded since reset.
module coherent_noise_1d_sampler #(
	parameter int TABLE_DEPTH     = 1024,
	parameter int COORD_FRAC_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// [31:0] x_coord, [41:32] entry_index, [57:42] entry_data, [63:58] zero
	input  wire logic [63:0] s_tdata,
	// [1:0] req_type
	input  wire logic [1:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [15:0] noise_out
	output logic [15:0]      m_tdata
);

	import cn1s_pkg::*;

	localparam int IDX_W      = $clog2(TABLE_DEPTH);
	localparam int FRAC_DOWN  = (COORD_FRAC_BITS >= 16) ? COORD_FRAC_BITS - 16 : 0;
	localparam int FRAC_UP    = (COORD_FRAC_BITS < 16) ? 16 - COORD_FRAC_BITS : 0;

	// stage 1: request register
	logic        vld_s1;
	logic [1:0]  req_s1;
	logic [31:0] x_s1;
	logic [9:0]  idx_s1;
	logic [15:0] data_s1;

	// stage 2: fraction terms, table data arrives from the RAMs
	logic        vld_s2;
	logic [15:0] f_s2;
	logic [16:0] g_s2;
	logic [31:0] ff_s2;

	logic                   is_smp, in_rng, go_s1, rdy_s2, mix_rdy;
	tbl_ctl_t               ctl;
	logic [31+IDX_W:0]      xe;
	logic [IDX_W-1:0]       i0;
	logic [15:0]            f_w;
	logic signed [15:0]     v1, v2, d1, d2;
	mix_in_t                mix_in;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			req_s1  <= s_tuser;
			x_s1    <= s_tdata[31:0];
			idx_s1  <= s_tdata[41:32];
			data_s1 <= s_tdata[57:42];
		end
	end

	// request decode and table port control
	always_comb begin
		ctl    = '0;
		is_smp = 1'b0;
		in_rng = 32'(idx_s1) < TABLE_DEPTH;
		case (req_type_t'(req_s1))
			REQ_SAMPLE: begin
				is_smp = 1'b1;
				ctl.rd = vld_s1 && rdy_s2;
			end
			REQ_LOAD_VALUE: begin
				ctl.wr_value = vld_s1 && in_rng;
			end
			REQ_LOAD_GRAD: begin
				ctl.wr_grad = vld_s1 && in_rng;
			end
			default: begin
			end
		endcase
	end

	// loads retire here, samples wait for stage 2
	assign go_s1    = vld_s1 && (!is_smp || rdy_s2);
	assign s_tready = !vld_s1 || go_s1;
	assign rdy_s2   = !vld_s2 || mix_rdy;

	// wrapped integer part and Q0.16 fraction
	always_comb begin
		xe  = {{IDX_W{x_s1[31]}}, x_s1};
		i0  = xe[COORD_FRAC_BITS +: IDX_W];
		f_w = 16'((40'(x_s1[COORD_FRAC_BITS-1:0]) >> FRAC_DOWN) << FRAC_UP);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (rdy_s2) begin
			vld_s2 <= vld_s1 && is_smp;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd) begin
			f_s2  <= f_w;
			g_s2  <= ONE_Q16 - {1'b0, f_w};
			ff_s2 <= 32'(f_w) * 32'(f_w);
		end
	end

	cn1s_tables #(.TABLE_DEPTH(TABLE_DEPTH)) u_tables (
		.clk(clk),
		.ctl(ctl),
		.waddr(IDX_W'(idx_s1)),
		.wdata(data_s1),
		.raddr(i0),
		.v1(v1),
		.v2(v2),
		.d1(d1),
		.d2(d2)
	);

	always_comb begin
		mix_in.f  = f_s2;
		mix_in.g  = g_s2;
		mix_in.ff = ff_s2;
		mix_in.v1 = v1;
		mix_in.v2 = v2;
		mix_in.d1 = d1;
		mix_in.d2 = d2;
	end

	cn1s_blend u_blend (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(vld_s2),
		.in_ready(mix_rdy),
		.in_data(mix_in),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_data(m_tdata)
	);

	`ASSERT_NEVER(a_tbl_one_op, clk, arst_n, (ctl.rd && (ctl.wr_value || ctl.wr_grad)) || (ctl.wr_value && ctl.wr_grad), "more than one table operation in a cycle")
	`ASSERT_CLK(a_load_no_sample, clk, arst_n, vld_s1 && !is_smp && rdy_s2 |=> !vld_s2, "load request reached stage 2")
	`ASSERT_CLK(a_s2_hold, clk, arst_n, vld_s2 && !mix_rdy |=> vld_s2 && $stable(ff_s2), "stage 2 lost its data while stalled")

endmodule

`default_nettype wire

// ===== hdl/cn1s_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module cn1s_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== hdl/cn1s_tables.sv =====
// Value and gradient tables, each held twice so both neighbors read at once.
`default_nettype none

module cn1s_tables #(
	parameter int TABLE_DEPTH = 1024,
	localparam int IDX_W = $clog2(TABLE_DEPTH)
) (
	input  wire logic              clk,
	input  wire cn1s_pkg::tbl_ctl_t ctl,
	input  wire logic [IDX_W-1:0]  waddr,
	input  wire logic [15:0]       wdata,
	input  wire logic [IDX_W-1:0]  raddr,
	output logic signed [15:0]     v1,
	output logic signed [15:0]     v2,
	output logic signed [15:0]     d1,
	output logic signed [15:0]     d2
);

	import cn1s_pkg::*;

	logic [IDX_W-1:0] raddr_nxt;
	logic [15:0]      v1_raw, v2_raw, d1_raw, d2_raw;

	// right neighbor, wrapping at the table end
	assign raddr_nxt = raddr + IDX_W'(1);

	cn1s_ram #(.WIDTH(16), .DEPTH(TABLE_DEPTH)) u_val_lo (
		.clk(clk), .we(ctl.wr_value), .waddr(waddr), .wdata(wdata),
		.re(ctl.rd), .raddr(raddr), .rdata(v1_raw)
	);

	cn1s_ram #(.WIDTH(16), .DEPTH(TABLE_DEPTH)) u_val_hi (
		.clk(clk), .we(ctl.wr_value), .waddr(waddr), .wdata(wdata),
		.re(ctl.rd), .raddr(raddr_nxt), .rdata(v2_raw)
	);

	cn1s_ram #(.WIDTH(16), .DEPTH(TABLE_DEPTH)) u_grad_lo (
		.clk(clk), .we(ctl.wr_grad), .waddr(waddr), .wdata(wdata),
		.re(ctl.rd), .raddr(raddr), .rdata(d1_raw)
	);

	cn1s_ram #(.WIDTH(16), .DEPTH(TABLE_DEPTH)) u_grad_hi (
		.clk(clk), .we(ctl.wr_grad), .waddr(waddr), .wdata(wdata),
		.re(ctl.rd), .raddr(raddr_nxt), .rdata(d2_raw)
	);

	assign v1 = $signed(v1_raw);
	assign v2 = $signed(v2_raw);
	assign d1 = $signed(d1_raw);
	assign d2 = $signed(d2_raw);

endmodule

`default_nettype wire

// ===== hdl/cn1s_blend.sv =====
// Smoothstep mix, gradient term, rounding and saturation in three stages.
`default_nettype none
`include "assert_macros.svh"

module cn1s_blend (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire cn1s_pkg::mix_in_t in_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [15:0]            out_data
);

	import cn1s_pkg::*;

	logic rdy_s3, rdy_s4, rdy_s5;
	logic vld_s3, vld_s4, vld_s5;

	// stage 3 operands
	logic [17:0]        w;
	logic [49:0]        sp;
	logic [32:0]        fgp;
	logic signed [33:0] dp1, dp2;
	logic [16:0]        s_s3;
	logic [14:0]        fg_s3;
	logic signed [33:0] diff_s3;
	logic signed [15:0] v1_s3, v2_s3;

	// stage 4 operands
	logic [16:0]        sc;
	logic signed [33:0] mixp_s4;
	logic signed [48:0] termp_s4;

	// stage 5 operands
	logic signed [33:0] mixr;
	logic signed [48:0] termr;
	logic signed [17:0] mixv;
	logic signed [18:0] termv;
	logic signed [19:0] sum;
	logic [15:0]        sat;

	// backpressure chain
	assign rdy_s5   = !vld_s5 || out_ready;
	assign rdy_s4   = !vld_s4 || rdy_s5;
	assign rdy_s3   = !vld_s3 || rdy_s4;
	assign in_ready = rdy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (rdy_s3) begin
				vld_s3 <= in_valid;
			end
			if (rdy_s4) begin
				vld_s4 <= vld_s3;
			end
			if (rdy_s5) begin
				vld_s5 <= vld_s4;
			end
		end
	end

	// smoothstep weight, f*(1-f) and gradient difference
	always_comb begin
		w   = 18'd196608 - 18'({in_data.f, 1'b0});
		sp  = 50'(in_data.ff) * 50'(w);
		fgp = 33'(in_data.f) * 33'(in_data.g);
		dp1 = 34'(in_data.d1) * 34'($signed({1'b0, in_data.g}));
		dp2 = 34'(in_data.d2) * 34'($signed({1'b0, in_data.f}));
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && in_valid) begin
			s_s3    <= 17'((sp + 50'h0_8000_0000) >> 32);
			fg_s3   <= 15'((fgp + 33'd32768) >> 16);
			diff_s3 <= dp1 - dp2;
			v1_s3   <= in_data.v1;
			v2_s3   <= in_data.v2;
		end
	end

	// weighted value mix and gradient product
	assign sc = ONE_Q16 - s_s3;

	always_ff @(posedge clk) begin
		if (rdy_s4 && vld_s3) begin
			mixp_s4  <= 34'(v1_s3) * 34'($signed({1'b0, sc}))
				+ 34'(v2_s3) * 34'($signed({1'b0, s_s3}));
			termp_s4 <= 49'(diff_s3) * 49'($signed({1'b0, fg_s3}));
		end
	end

	// round half up, add, clamp to Q2.14
	always_comb begin
		mixr  = mixp_s4 + 34'sd32768;
		termr = termp_s4 + 49'sd536870912;
		mixv  = 18'(mixr >>> 16);
		termv = 19'(termr >>> 30);
		sum   = 20'(mixv) + 20'(termv);
		if (sum > 20'sd32767) begin
			sat = 16'h7fff;
		end else if (sum < -20'sd32768) begin
			sat = 16'h8000;
		end else begin
			sat = sum[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s5 && vld_s4) begin
			out_data <= sat;
		end
	end

	assign out_valid = vld_s5;

	`ASSERT_CLK(a_weight_range, clk, arst_n, vld_s3 |-> s_s3 <= ONE_Q16, "smoothstep weight above one")
	`ASSERT_CLK(a_fg_range, clk, arst_n, vld_s3 |-> fg_s3 <= 15'd16384, "f*(1-f) above one quarter")
	`ASSERT_CLK(a_s4_hold, clk, arst_n, vld_s4 && !rdy_s5 |=> vld_s4 && $stable(mixp_s4), "stage 4 lost its data while stalled")

endmodule

`default_nettype wire

// ===== tb/coherent_noise_1d_sampler_tb.sv =====
// Self-checking testbench for the 1D coherent noise sampler: table loads and samples.
`timescale 1ns / 100ps

module coherent_noise_1d_sampler_tb;
	import cn1s_pkg::*;

	localparam int DEPTH      = 1024;
	localparam int FRAC_BITS  = 16;
	localparam int FRAC_DOWN  = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
	localparam int FRAC_UP    = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
	localparam longint UNIT   = 65536;
	localparam int RAND_ITEMS = 1050;

	// tuser code the block must ignore
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	typedef struct {
		logic [1:0]  kind;
		logic [31:0] coord;
		logic [9:0]  index;
		logic [15:0] data;
		int          gap;
		bit          drain;
	} noise_req_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;

	// request queue, expected samples and the predicted tables
	noise_req_t        pending_reqs[$];
	logic [15:0]       expected_noise[$];
	logic signed [15:0] val_tbl[DEPTH];
	logic signed [15:0] grad_tbl[DEPTH];

	// generator bookkeeping: which entries are loaded, which pairs may be sampled
	bit         val_seen[DEPTH];
	bit         grad_seen[DEPTH];
	bit         ready_mark[DEPTH];
	logic [9:0] ready_idx[$];
	bit         tx_quiet = 1'b0;
	bit         drain_next = 1'b0;
	int         total_reqs = 0;

	// driver and monitor state
	noise_req_t  cur_req;
	bit          holding;
	int          wait_left;
	int          taken = 0;
	int          stall_left;
	bit          rx_quiet = 1'b0;
	logic [15:0] want;
	int          errors = 0;

	coherent_noise_1d_sampler #(
		.TABLE_DEPTH     (DEPTH),
		.COORD_FRAC_BITS (FRAC_BITS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// expected Q2.14 sample at a coordinate, from the predicted tables
	function automatic logic [15:0] noise_at(input logic [31:0] coord);
		logic signed [31:0] whole;
		longint f, g, s, mix, fg, diff, term, sum;
		int i0, i1;
		whole = $signed(coord) >>> FRAC_BITS;
		// floor mod a power-of-two depth is a mask
		i0 = int'(whole) & (DEPTH - 1);
		i1 = (i0 + 1) & (DEPTH - 1);
		f = ((longint'(coord) & ((longint'(1) << FRAC_BITS) - 1)) >> FRAC_DOWN) << FRAC_UP;
		g = UNIT - f;
		s = (f * f * (3 * UNIT - 2 * f) + (longint'(1) << 31)) >>> 32;
		mix = (val_tbl[i0] * (UNIT - s) + val_tbl[i1] * s + 32768) >>> 16;
		fg = (f * g + 32768) >>> 16;
		diff = grad_tbl[i0] * g - grad_tbl[i1] * f;
		term = (diff * fg + (longint'(1) << 29)) >>> 30;
		sum = mix + term;
		if (sum > 32767)
			sum = 32767;
		else if (sum < -32768)
			sum = -32768;
		return sum[15:0];
	endfunction

	// entry i may be sampled once both tables hold i and i+1
	function automatic void mark_ready(input logic [9:0] i);
		if (!ready_mark[i] && val_seen[i] && grad_seen[i] &&
				val_seen[i + 10'd1] && grad_seen[i + 10'd1]) begin
			ready_mark[i] = 1'b1;
			ready_idx.push_back(i);
		end
	endfunction

	task automatic push_req(input logic [1:0] kind, input logic [31:0] coord,
			input logic [9:0] index, input logic [15:0] data);
		noise_req_t rq;
		rq.kind  = kind;
		rq.coord = coord;
		rq.index = index;
		rq.data  = data;
		rq.gap   = tx_quiet ? 0 : $urandom_range(0, 13);
		rq.drain = drain_next;
		drain_next = 1'b0;
		pending_reqs.push_back(rq);
		total_reqs++;
		if (kind == REQ_LOAD_VALUE)
			val_seen[index] = 1'b1;
		if (kind == REQ_LOAD_GRAD)
			grad_seen[index] = 1'b1;
		if (kind == REQ_LOAD_VALUE || kind == REQ_LOAD_GRAD) begin
			mark_ready(index - 10'd1);
			mark_ready(index);
		end
	endtask

	// Q16.16 coordinate landing on table entry idx, random upper integer bits
	function automatic logic [31:0] coord_at(input logic [9:0] idx, input logic [15:0] frac);
		logic [5:0] top;
		top = 6'($urandom_range(0, 63));
		return {top, idx, frac};
	endfunction

	function automatic logic [15:0] rand_word();
		case ($urandom_range(0, 9))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0000;
			default: return 16'($urandom());
		endcase
	endfunction

	function automatic logic [15:0] rand_frac();
		case ($urandom_range(0, 9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'h8000;
			3: return 16'h0001;
			default: return 16'($urandom());
		endcase
	endfunction

	// request driver: hold-off gap, optional drain, then present
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			holding = 1'b0;
			wait_left = 0;
		end else begin
			// update the prediction with the request taken at this edge
			if (s_tvalid && s_tready) begin
				taken++;
				case (cur_req.kind)
					REQ_SAMPLE: expected_noise.push_back(noise_at(cur_req.coord));
					REQ_LOAD_VALUE: begin
						if (int'(cur_req.index) < DEPTH)
							val_tbl[cur_req.index] = cur_req.data;
					end
					REQ_LOAD_GRAD: begin
						if (int'(cur_req.index) < DEPTH)
							grad_tbl[cur_req.index] = cur_req.data;
					end
					default: ;
				endcase
			end
			if (!s_tvalid || s_tready) begin
				if (!holding && pending_reqs.size() != 0) begin
					cur_req = pending_reqs.pop_front();
					holding = 1'b1;
					wait_left = cur_req.gap;
				end
				if (holding && wait_left == 0 &&
						!(cur_req.drain && expected_noise.size() != 0)) begin
					s_tvalid <= 1'b1;
					s_tdata <= {6'd0, cur_req.data, cur_req.index, cur_req.coord};
					s_tuser <= cur_req.kind;
					holding = 1'b0;
				end else begin
					if (wait_left > 0)
						wait_left--;
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result monitor with random back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_noise.size() == 0) begin
					$error("noise_out: expected none, actual %0d", $signed(m_tdata));
					errors++;
				end else begin
					want = expected_noise.pop_front();
					if (m_tdata !== want) begin
						$error("noise_out: expected %0d, actual %0d",
							$signed(want), $signed(m_tdata));
						errors++;
					end
				end
				stall_left = rx_quiet ? 0 : $urandom_range(0, 13);
				if ($urandom_range(0, 39) == 0)
					rx_quiet = !rx_quiet;
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else
				m_tready <= 1'b1;
		end
	end

	// stimulus, reset and end of run
	initial begin : stim
		int n, r, k, phase_end;
		logic [9:0] idx;
		// directed: extreme words around the wrap, a saturating pair each way
		push_req(REQ_LOAD_VALUE, 32'h0, 10'd1023, 16'h7FFF);
		push_req(REQ_LOAD_VALUE, 32'h0, 10'd0, 16'h8000);
		push_req(REQ_LOAD_VALUE, 32'h0, 10'd1, 16'h0000);
		push_req(REQ_LOAD_GRAD, 32'h0, 10'd1023, 16'h7FFF);
		push_req(REQ_LOAD_GRAD, 32'h0, 10'd0, 16'h8000);
		push_req(REQ_LOAD_GRAD, 32'h0, 10'd1, 16'h1000);
		push_req(REQ_LOAD_VALUE, 32'hFFFF_FFFF, 10'd2, 16'h7FFF);
		push_req(REQ_LOAD_VALUE, 32'hFFFF_FFFF, 10'd3, 16'h7FFF);
		push_req(REQ_LOAD_GRAD, 32'hFFFF_FFFF, 10'd2, 16'h7FFF);
		push_req(REQ_LOAD_GRAD, 32'hFFFF_FFFF, 10'd3, 16'h8000);
		push_req(REQ_LOAD_VALUE, 32'h0, 10'd5, 16'h8000);
		push_req(REQ_LOAD_VALUE, 32'h0, 10'd6, 16'h8000);
		push_req(REQ_LOAD_GRAD, 32'h0, 10'd5, 16'h8000);
		push_req(REQ_LOAD_GRAD, 32'h0, 10'd6, 16'h7FFF);
		// ignored request kind must not touch entry 4 or give a sample
		push_req(REQ_UNUSED, 32'h0004_8000, 10'd4, 16'h5A5A);
		push_req(REQ_SAMPLE, 32'h0000_0000, 10'd0, 16'h0);
		push_req(REQ_SAMPLE, 32'h0000_0001, 10'd0, 16'h0);
		push_req(REQ_SAMPLE, 32'h0000_C000, 10'd0, 16'h0);
		push_req(REQ_SAMPLE, 32'h03FF_FFFF, 10'd0, 16'h0);
		push_req(REQ_SAMPLE, 32'h03FF_8000, 10'd0, 16'h0);
		push_req(REQ_SAMPLE, 32'h8000_0000, 10'd0, 16'h0);
		push_req(REQ_SAMPLE, 32'h7FFF_FFFF, 10'd0, 16'h0);
		push_req(REQ_SAMPLE, 32'hFFFF_FFFF, 10'd0, 16'h0);
		push_req(REQ_SAMPLE, 32'h0002_8000, 10'd0, 16'h0);
		push_req(REQ_SAMPLE, 32'h0005_8000, 10'd0, 16'h0);

		// random: mostly load-a-pair-then-sample sequences and samples on loaded pairs
		n = 0;
		phase_end = 0;
		while (n < RAND_ITEMS) begin
			if (n >= phase_end) begin
				phase_end = n + $urandom_range(60, 160);
				tx_quiet = ($urandom_range(0, 2) == 0);
				drain_next = 1'b1;
			end
			r = $urandom_range(0, 99);
			if (r < 14) begin
				idx = 10'($urandom_range(0, DEPTH - 1));
				push_req(REQ_LOAD_VALUE, $urandom(), idx, rand_word());
				push_req(REQ_LOAD_GRAD, $urandom(), idx + 10'd1, rand_word());
				push_req(REQ_LOAD_VALUE, $urandom(), idx + 10'd1, rand_word());
				push_req(REQ_LOAD_GRAD, $urandom(), idx, rand_word());
				k = $urandom_range(1, 3);
				repeat (k)
					push_req(REQ_SAMPLE, coord_at(idx, rand_frac()),
						10'($urandom()), 16'($urandom()));
				n += 4 + k;
			end else if (r < 22) begin
				push_req(($urandom_range(0, 1) != 0) ? REQ_LOAD_VALUE : REQ_LOAD_GRAD,
					$urandom(), 10'($urandom_range(0, DEPTH - 1)), rand_word());
				n++;
			end else if (r < 25) begin
				push_req(REQ_UNUSED, $urandom(), 10'($urandom()), 16'($urandom()));
			end else begin
				idx = ready_idx[$urandom_range(0, ready_idx.size() - 1)];
				push_req(REQ_SAMPLE, coord_at(idx, rand_frac()),
					10'($urandom()), 16'($urandom()));
				n++;
			end
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (taken != total_reqs)
			@(posedge clk);
		while (expected_noise.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);

		if (errors == 0)
			$display("coherent_noise_1d_sampler_tb OK");
		else
			$display("coherent_noise_1d_sampler_tb NOT OK");
		$finish;
	end

	// hang guard
	initial begin
		#10_000_000;
		$display("coherent_noise_1d_sampler_tb NOT OK");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/cn1s_pkg.sv
hdl/cn1s_ram.sv
hdl/cn1s_tables.sv
hdl/cn1s_blend.sv
hdl/coherent_noise_1d_sampler.sv
tb/coherent_noise_1d_sampler_tb.sv
